// ===== sv/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// Pad pedestal accumulator package
// Shared types, command codes and sizing constants.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int unsigned ROWS_DEF = 128;
  localparam int unsigned COLS_DEF = 128;

  typedef enum logic [1:0] {
    CMD_HIT   = 2'd0,
    CMD_EOE   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_EVT = 2'd1,
    ST_NEG    = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         hit_sector;
    logic [6:0]         pad_row;
    logic [6:0]         pad_col;
    logic signed [15:0] charge;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mean;
    logic [14:0]        sigma;
    logic [31:0]        pad_hits;
    logic [31:0]        events_seen;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIPE,
    S_RD,
    S_RMW,
    S_QRD,
    S_DIV,
    S_SQ,
    S_SQRT,
    S_DONE
  } fsm_t;

endpackage

// ===== sv/pad_pedestal_accumulator.sv =====
// ----------------------------------------------------------------------------
// Pad pedestal accumulator
// Per-pad charge sum, square sum and hit count in block memory, with mean and
// sigma reporting through a shared serial divider and square root unit.
// ----------------------------------------------------------------------------
// Timing: a matched hit keeps busy high through the read state and the modify
// and write back state, and the next hit waits for it; other hits keep busy high
// through the read state only, and an end of event not at all. A read runs the
// 64-step divider twice and then the square root, both skipped with no events yet;
// its result strobe is registered from S_DONE. A clear or reset sweeps the memory,
// every pad, while busy is high; results cannot be stalled.
module pad_pedestal_accumulator #(
  parameter int unsigned ROWS = ppa_pkg::ROWS_DEF,
  parameter int unsigned COLS = ppa_pkg::COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ppa_pkg::in_item_t in_item,
  output logic              result_valid,
  output ppa_pkg::out_item_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data
);
  import ppa_pkg::*;

  localparam int unsigned PADS = ROWS * COLS;
  localparam int unsigned AW   = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int unsigned MW   = 48 + 64 + 32;

  // Memory: {charge_sum, square_sum, hit_count}.
  logic [MW-1:0] mem [PADS];
  logic [MW-1:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [MW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  fsm_t state, state_next;
  logic [2:0]  sector_select;
  logic [31:0] event_count;
  logic        has_data, stopped;
  in_item_t    item;
  logic        on_grid;
  logic [AW:0] wipe;
  logic [AW-1:0] idx;
  logic        wipe_last;

  // Divider / sqrt datapath.
  logic [63:0] dq;      // dividend shifting into quotient
  logic [63:0] drem;    // remainder
  logic [6:0]  cnt;
  logic        pass;    // 0 = charge magnitude, 1 = square sum
  logic        neg;
  logic [63:0] mq, ms;
  logic [63:0] prod;
  logic [31:0] s_r;
  logic [65:0] s_rem;
  logic [63:0] s_x;
  logic [31:0] hits_r;
  logic [63:0] q_r;
  logic        hit_ok;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign wipe_last = (wipe[AW-1:0] == AW'(PADS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_select <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sector_select <= cfg_data;
    end
  end

  always_comb begin
    on_grid = ({2'b0, item.pad_row} < 9'(ROWS)) && ({2'b0, item.pad_col} < 9'(COLS));
    idx     = on_grid ? AW'(32'(item.pad_row) * COLS + 32'(item.pad_col)) : '0;
  end

  // 64-bit restoring divide step by event_count.
  logic [64:0] trial;
  assign trial = {drem, dq[63]} - {33'd0, event_count};

  // Square root step: two bits of radicand per cycle.
  logic [65:0] s_trial;
  assign s_trial = {s_rem[63:0], s_x[63:62]} - {32'd0, s_r, 2'b01};

  logic [47:0] cs_mem;
  assign cs_mem = rd_data[MW-1 -: 48];

  always_comb begin
    state_next = state;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = {rd_data[MW-1 -: 48] + {{32{item.charge[15]}}, item.charge},
                  rd_data[95:32] + 64'($signed(32'(item.charge) * 32'(item.charge))),
                  rd_data[31:0] + 32'd1};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_item.cmd))
            CMD_HIT:   state_next = S_RD;
            CMD_EOE:   state_next = S_IDLE;
            CMD_READ:  state_next = S_RD;
            CMD_CLEAR: state_next = S_WIPE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_WIPE: begin
        wr_en   = 1'b1;
        wr_addr = wipe[AW-1:0];
        wr_data = '0;
        if (wipe_last) state_next = S_IDLE;
      end
      S_RD: begin
        if (item.cmd == CMD_HIT) begin
          // The hit only proceeds to write back when the pad is on the grid.
          state_next = (hit_ok && on_grid) ? S_RMW : S_IDLE;
        end else begin
          state_next = S_QRD;
        end
      end
      S_RMW: begin
        wr_en      = 1'b1;
        state_next = S_IDLE;
      end
      S_QRD: begin
        state_next = (event_count == 32'd0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (cnt == 7'd63 && pass) state_next = S_SQ;
      end
      S_SQ: begin
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (cnt == 7'd32) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WIPE;
      wipe         <= '0;
      event_count  <= '0;
      has_data     <= 1'b0;
      stopped      <= 1'b0;
      result_valid <= 1'b0;
      hit_ok       <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          wipe <= '0;
          if (start) begin
            item <= in_item;
            unique case (cmd_t'(in_item.cmd))
              CMD_HIT: begin
                hit_ok <= !stopped && (in_item.hit_sector == sector_select);
                if (!stopped) begin
                  has_data <= 1'b1;
                  if (in_item.hit_sector != sector_select) begin
                    stopped <= 1'b1;
                  end
                end
              end
              CMD_EOE: begin
                if (has_data && event_count != 32'hFFFF_FFFF) begin
                  event_count <= event_count + 32'd1;
                end
                has_data <= 1'b0;
                stopped  <= 1'b0;
              end
              CMD_CLEAR: begin
                event_count <= '0;
                has_data    <= 1'b0;
                stopped     <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WIPE: wipe <= wipe + 1'b1;
        S_QRD: begin
          hits_r <= on_grid ? rd_data[31:0] : 32'd0;
          q_r    <= on_grid ? rd_data[95:32] : 64'd0;
          neg    <= on_grid & cs_mem[47];
          dq     <= on_grid ? (cs_mem[47] ? 64'd0 - {{16{cs_mem[47]}}, cs_mem}
                                          : {16'd0, cs_mem}) : 64'd0;
          drem   <= '0;
          cnt    <= '0;
          pass   <= 1'b0;
        end
        S_DIV: begin
          if (cnt == 7'd63) begin
            cnt <= '0;
            if (!pass) begin
              mq   <= {dq[62:0], !trial[64]};
              dq   <= q_r;
              drem <= '0;
              pass <= 1'b1;
            end else begin
              ms <= {dq[62:0], !trial[64]};
            end
          end else begin
            cnt <= cnt + 7'd1;
            if (!trial[64]) begin
              drem <= trial[63:0];
              dq   <= {dq[62:0], 1'b1};
            end else begin
              drem <= {drem[62:0], dq[63]};
              dq   <= {dq[62:0], 1'b0};
            end
          end
        end
        S_SQ: begin
          prod  <= mq[31:0] * mq[31:0];
          s_r   <= '0;
          s_rem <= '0;
        end
        S_SQRT: begin
          // A load step, then 32 steps of two radicand bits each.
          cnt <= cnt + 7'd1;
          if (cnt == 7'd0) begin
            s_x <= ms - prod;
          end else begin
            if (!s_trial[65]) begin
              s_rem <= s_trial;
              s_r   <= {s_r[30:0], 1'b1};
            end else begin
              s_rem <= {s_rem[63:0], s_x[63:62]};
              s_r   <= {s_r[30:0], 1'b0};
            end
            s_x <= {s_x[61:0], 2'b00};
          end
        end
        S_DONE: begin
          result.pad_hits    <= hits_r;
          result.events_seen <= event_count;
          if (event_count == 32'd0) begin
            result.mean   <= '0;
            result.sigma  <= '0;
            result.status <= ST_NO_EVT;
          end else begin
            if (!neg) begin
              result.mean <= (mq > 64'd32767) ? 16'sh7FFF : mq[15:0];
            end else begin
              result.mean <= (mq > 64'd32768) ? 16'sh8000 : 16'(-mq[15:0]);
            end
            if (mq[63:32] != 32'd0 || ms < prod) begin
              result.sigma  <= '0;
              result.status <= ST_NEG;
            end else begin
              result.sigma  <= (s_r > 32'd32767) ? 15'h7FFF : s_r[14:0];
              result.status <= ST_OK;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ppa_checker.sv =====
// ----------------------------------------------------------------------------
// Pad pedestal accumulator port checker
// Port-level properties of the command and result handshakes.
// ----------------------------------------------------------------------------
module ppa_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               result_valid,
  input ppa_pkg::out_item_t result
);
  import ppa_pkg::*;

  // A result always closes a busy period.
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without work");

  // A result strobe lasts one cycle.
  a_res_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe too long");

  // With no events, mean and sigma are zero.
  a_noevt: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_NO_EVT) |-> (result.mean == 16'sd0 &&
    result.sigma == 15'd0)) else $error("stats without events");

  // Status never takes the unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_OK || result.status == ST_NO_EVT ||
    result.status == ST_NEG)) else $error("bad status");

endmodule

bind pad_pedestal_accumulator ppa_checker u_ppa_checker (
  .clk(clk), .rst(rst), .busy(busy),
  .result_valid(result_valid), .result(result)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad pedestal accumulator testbench
// Drives hit, end-of-event, read and clear commands through the start/busy
// port and checks every read answer against a behavioral model of the pad
// stores, including sector stops, saturation and error status codes.
// ----------------------------------------------------------------------------
module tb_top;
  import ppa_pkg::*;

  localparam int unsigned NPADS = 128 * 128;
  localparam longint unsigned LIMIT = 64'd4_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic result_valid;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = '0;

  pad_pedestal_accumulator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model state of the pad stores.
  logic [47:0] pad_sum [NPADS];
  logic [63:0] pad_sq [NPADS];
  logic [31:0] pad_cnt [NPADS];
  logic [31:0] evt_count;
  logic evt_data, evt_stop;
  logic [2:0] sel_sector;

  in_item_t pending_cmds [$];
  out_item_t expected_stats [$];
  int errors = 0;
  longint unsigned cycles = 0;
  logic quiet = 1'b0;

  // Busy as seen at the last rising edge, so the driver knows what was taken.
  logic busy_s = 1'b1;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic wipe_model();
    for (int i = 0; i < NPADS; i++) begin
      pad_sum[i] = '0;
      pad_sq[i] = '0;
      pad_cnt[i] = '0;
    end
    evt_count = '0;
    evt_data = 1'b0;
    evt_stop = 1'b0;
  endtask

  task automatic predict_stats(input in_item_t it);
    int idx;
    longint signed c, s, m;
    logic [63:0] mag, mq, ms, q, n;
    out_item_t r;
    idx = it.pad_row * 128 + it.pad_col;
    c = it.charge;
    case (cmd_t'(it.cmd))
      CMD_HIT: begin
        if (!evt_stop) begin
          evt_data = 1'b1;
          if (it.hit_sector != sel_sector) begin
            evt_stop = 1'b1;
          end else begin
            pad_sum[idx] = pad_sum[idx] + 48'(c);
            pad_sq[idx] = pad_sq[idx] + 64'(c * c);
            pad_cnt[idx] = pad_cnt[idx] + 1;
          end
        end
      end
      CMD_EOE: begin
        if (evt_data && evt_count != 32'hFFFF_FFFF) evt_count++;
        evt_data = 1'b0;
        evt_stop = 1'b0;
      end
      CMD_CLEAR: wipe_model();
      default: begin
        r = '0;
        r.pad_hits = pad_cnt[idx];
        r.events_seen = evt_count;
        if (evt_count == 0) begin
          r.status = ST_NO_EVT;
        end else begin
          s = longint'($signed(pad_sum[idx]));
          q = pad_sq[idx];
          n = evt_count;
          mag = (s < 0) ? 64'(-s) : 64'(s);
          mq = mag / n;
          ms = q / n;
          m = (s < 0) ? -longint'(mq) : longint'(mq);
          if (m > 32767) r.mean = 16'sh7FFF;
          else if (m < -32768) r.mean = 16'sh8000;
          else r.mean = 16'(m);
          if (mq >= 64'h1_0000_0000 || ms < mq * mq) begin
            r.status = ST_NEG;
          end else begin
            q = int_sqrt(ms - mq * mq);
            r.sigma = (q > 32767) ? 15'h7FFF : q[14:0];
            r.status = ST_OK;
          end
        end
        expected_stats.push_back(r);
      end
    endcase
  endtask

  // Driver: falling edge, the queue head is offered until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_s) void'(pending_cmds.pop_front());
      if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
        start <= 1'b1;
        in_item <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    busy_s <= busy;
    if (!rst && start && !busy) predict_stats(in_item);
    if (!rst && result_valid) begin
      if (expected_stats.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        out_item_t e;
        e = expected_stats.pop_front();
        if (result.mean !== e.mean) begin
          $error("mean exp %0d got %0d", e.mean, result.mean); errors++;
        end
        if (result.sigma !== e.sigma) begin
          $error("sigma exp %0d got %0d", e.sigma, result.sigma); errors++;
        end
        if (result.pad_hits !== e.pad_hits) begin
          $error("pad_hits exp %0d got %0d", e.pad_hits, result.pad_hits); errors++;
        end
        if (result.events_seen !== e.events_seen) begin
          $error("events_seen exp %0d got %0d", e.events_seen, result.events_seen);
          errors++;
        end
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status); errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_item_t mk(input cmd_t cm, input int sec, input int r,
                                  input int c, input int q);
    in_item_t it;
    it.cmd = cm;
    it.hit_sector = 3'(sec);
    it.pad_row = 7'(r);
    it.pad_col = 7'(c);
    it.charge = 16'(q);
    return it;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    @(posedge clk);
    wait (!busy && expected_stats.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_sector(input logic [2:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sel_sector = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random events on a few hot pads, mostly well formed, some broken.
  task automatic random_phase(input int n, input logic [2:0] sec);
    logic [6:0] r, c;
    int k;
    k = 0;
    while (k < n) begin
      int hits;
      hits = $urandom_range(1, 6);
      for (int h = 0; h < hits; h++) begin
        r = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(3));
        c = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(3));
        pending_cmds.push_back(mk(CMD_HIT,
          ($urandom_range(9) == 0) ? 3'($urandom) : sec, r, c,
          ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200 + 800)));
        k++;
      end
      if ($urandom_range(7) != 0) begin
        pending_cmds.push_back(mk(CMD_EOE, 3'($urandom), 7'($urandom), 7'($urandom), 16'($urandom)));
        k++;
      end
      if ($urandom_range(2) == 0) begin
        pending_cmds.push_back(mk(CMD_READ, 3'($urandom), 7'($urandom_range(3)),
          7'($urandom_range(3)), 16'($urandom)));
        k++;
      end
    end
    pending_cmds.push_back(mk(CMD_READ, 0, 7'd127, 7'd127, 0));
  endtask

  initial begin
    wipe_model();
    sel_sector = 3'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: no events, extremes of charge, sector stop, extreme pads, clear.
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_EOE, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_HIT, 0, 0, 0, 16'h7FFF));
    pending_cmds.push_back(mk(CMD_HIT, 0, 127, 127, 16'h8000));
    pending_cmds.push_back(mk(CMD_HIT, 0, 0, 0, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_HIT, 7, 5, 5, 16'h0010));
    pending_cmds.push_back(mk(CMD_HIT, 0, 0, 0, 16'h1234));
    pending_cmds.push_back(mk(CMD_EOE, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 127, 127, 0));
    pending_cmds.push_back(mk(CMD_HIT, 0, 1, 1, 16'h8000));
    pending_cmds.push_back(mk(CMD_HIT, 0, 1, 1, 16'h7FFF));
    pending_cmds.push_back(mk(CMD_EOE, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 1, 1, 0));
    pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 1, 1, 0));
    drain();
    write_sector(3'd5);
    random_phase(150, 3'd5);
    drain();
    write_sector(3'd7);
    quiet = 1'b1;
    random_phase(200, 3'd7);
    drain();
    quiet = 1'b0;
    write_sector(3'd0);
    pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
    random_phase(200, 3'd0);
    drain();
    write_sector(3'd3);
    random_phase(150, 3'd3);
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
